@@ rtl/core/ssww_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssww_pkg: shared types and constants for the whole-word substring search
// Configuration bundle, queue entry layout and register indexes.
// ----------------------------------------------------------------------------
package ssww_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [2:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [2:0] REG_PATTERN_LEN  = 3'd2;
    localparam logic [2:0] REG_IGNORE_CASE  = 3'd3;
    localparam logic [2:0] REG_WHOLE_WORD   = 3'd4;
    localparam logic [2:0] REG_MATCH_LIMIT  = 3'd5;

    // Pattern bytes held by the two pattern registers
    localparam int PAT_LOW_BYTES = 8;
    localparam int PAT_REG_BYTES = 16;

    // Count saturation value
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Depth of the front-to-back queue
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [63:0] pattern_low;
        logic [63:0] pattern_high;
        logic [4:0]  pattern_length;
        logic        ignore_case;
        logic        whole_word;
        logic [15:0] match_limit;
    } cfg_t;

    // Classified byte handed from front to back
    typedef struct packed {
        logic        late_hit;   // match ending on the previous byte
        logic        end_hit;    // match ending on this (last) byte
        logic        last;       // this byte ends the text
        logic [31:0] late_pos;
        logic [31:0] end_pos;
    } q_entry_t;

endpackage
`default_nettype wire

@@ rtl/core/ssww_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssww_front: byte intake and match classification
// Keeps the byte history, compares it against the aligned pattern and pushes
// candidate matches and end-of-text markers into the queue.
// ----------------------------------------------------------------------------
module ssww_front #(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ssww_pkg::cfg_t    cfg,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_text_byte,
    input  wire logic              s_last_byte,
    input  wire logic              q_full,
    output logic                   q_push,
    output ssww_pkg::q_entry_t     q_entry
);

    localparam int HD  = MAX_PATTERN + 1;
    localparam int LW  = $clog2(MAX_PATTERN + 1);
    localparam int FW  = $clog2(HD + 1);
    localparam int PIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        if (ic && c >= "A" && c <= "Z") begin
            return c | 8'h20;
        end
        return c;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9");
    endfunction

    logic [7:0]    hist_reg [HD];
    logic [FW-1:0] fill_reg;
    logic [31:0]   pos_reg;

    logic [7:0]    pat_b   [MAX_PATTERN];
    logic [7:0]    rev     [MAX_PATTERN];
    logic [LW-1:0] rev_idx [MAX_PATTERN];
    logic [LW-1:0] len;
    logic [LW-1:0] len_m1;
    logic          late_eq;
    logic          end_eq;
    logic          late_cand;
    logic          end_cand;
    logic          accept;

    // Pattern bytes from the two configuration words
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_pat
        if (g < ssww_pkg::PAT_LOW_BYTES) begin : g_low
            assign pat_b[g] = cfg.pattern_low[8*g +: 8];
        end else if (g < ssww_pkg::PAT_REG_BYTES) begin : g_high
            assign pat_b[g] = cfg.pattern_high[8*(g-ssww_pkg::PAT_LOW_BYTES) +: 8];
        end else begin : g_zero
            assign pat_b[g] = 8'h00;
        end
    end

    // Effective length, clipped to the window
    always_comb begin
        if (32'(cfg.pattern_length) > MAX_PATTERN) begin
            len = LW'(MAX_PATTERN);
        end else begin
            len = LW'(cfg.pattern_length);
        end
        len_m1 = len - LW'(1);
    end

    // Pattern reversed so that rev[0] is its last byte
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            rev_idx[k] = len - LW'(k) - LW'(1);
            rev[k]     = (LW'(k) < len) ? pat_b[rev_idx[k][PIW-1:0]] : 8'h00;
        end
    end

    // Parallel compare: late aligns on history, end aligns on current byte
    always_comb begin
        late_eq = 1'b1;
        end_eq  = (fold(s_text_byte, cfg.ignore_case) == fold(rev[0], cfg.ignore_case));
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (LW'(k) < len &&
                fold(hist_reg[k], cfg.ignore_case) != fold(rev[k], cfg.ignore_case)) begin
                late_eq = 1'b0;
            end
        end
        for (int k = 0; k < MAX_PATTERN - 1; k++) begin
            if (LW'(k + 1) < len &&
                fold(hist_reg[k], cfg.ignore_case) != fold(rev[k+1], cfg.ignore_case)) begin
                end_eq = 1'b0;
            end
        end
    end

    // Fill and word-boundary qualification
    always_comb begin
        late_cand = (len != '0) && (32'(len) <= 32'(fill_reg)) && late_eq;
        if (cfg.whole_word) begin
            if (is_word(s_text_byte)) begin
                late_cand = 1'b0;
            end
            if (32'(len) < 32'(fill_reg) && is_word(hist_reg[len])) begin
                late_cand = 1'b0;
            end
        end
        end_cand = (len != '0) && (32'(len) <= 32'(fill_reg) + 32'd1) && end_eq;
        if (cfg.whole_word && 32'(len) <= 32'(fill_reg) && is_word(hist_reg[len_m1])) begin
            end_cand = 1'b0;
        end
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (late_cand || s_last_byte);

    always_comb begin
        q_entry.late_hit = late_cand;
        q_entry.end_hit  = end_cand;
        q_entry.last     = s_last_byte;
        q_entry.late_pos = pos_reg - 32'(len);
        q_entry.end_pos  = pos_reg - 32'(len) + 32'd1;
    end

    // Stream state: fill level and byte offset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            pos_reg  <= '0;
        end else if (accept) begin
            if (s_last_byte) begin
                fill_reg <= '0;
                pos_reg  <= '0;
            end else begin
                if (fill_reg < FW'(HD)) begin
                    fill_reg <= fill_reg + FW'(1);
                end
                pos_reg <= pos_reg + 32'd1;
            end
        end
    end

    // History window; entries beyond the fill level are never used
    always_ff @(posedge aclk) begin
        if (accept && !s_last_byte) begin
            hist_reg[0] <= s_text_byte;
            for (int i = 1; i < HD; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ssww_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssww_queue: short queue between front and back
// Two-entry FIFO of classified bytes; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module ssww_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_push,
    input  wire ssww_pkg::q_entry_t q_entry,
    output logic                    q_full,
    input  wire logic               q_pop,
    output logic                    q_empty,
    output ssww_pkg::q_entry_t      q_head
);

    localparam int CW = $clog2(ssww_pkg::Q_DEPTH + 1);
    localparam int PW = $clog2(ssww_pkg::Q_DEPTH);

    ssww_pkg::q_entry_t slot_reg [ssww_pkg::Q_DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [CW-1:0]      count_reg;
    logic               do_push;
    logic               do_pop;

    assign q_full  = (count_reg == CW'(ssww_pkg::Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_head  = slot_reg[rd_ptr_reg];
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;

    // Pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= q_entry;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ssww_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssww_back: match limiting and result output
// Applies the match limit and count, emits the late match and the end item,
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module ssww_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [15:0]        match_limit,
    input  wire logic               q_empty,
    input  wire ssww_pkg::q_entry_t q_head,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_match_found,
    output logic [31:0]             m_match_position,
    output logic                    m_search_done,
    output logic [15:0]             m_matches_so_far
);

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        return (c < ssww_pkg::COUNT_MAX) ? c + 16'd1 : c;
    endfunction

    logic        m_valid_reg;
    logic        m_valid_next;
    logic        m_found_reg;
    logic        m_found_next;
    logic [31:0] m_pos_reg;
    logic [31:0] m_pos_next;
    logic        m_done_reg;
    logic        m_done_next;
    logic [15:0] m_count_reg;
    logic [15:0] m_count_next;

    logic [15:0] cnt_reg;
    logic [15:0] cnt_next;
    logic        stop_reg;
    logic        stop_next;
    logic        phase_reg;   // late part of the head entry already sent
    logic        phase_next;

    logic        can_load;
    logic        may;
    logic        late_rep;
    logic [15:0] cnt_late;
    logic        end_rep;
    logic [15:0] cnt_end;

    assign can_load = !m_valid_reg || m_ready;
    assign may      = !stop_reg && (match_limit == 16'd0 || cnt_reg < match_limit);
    assign late_rep = q_head.late_hit && may;
    assign cnt_late = sat_inc(cnt_reg);
    assign end_rep  = q_head.end_hit && may;
    assign cnt_end  = end_rep ? sat_inc(cnt_reg) : cnt_reg;

    // Result sequencing for the head entry
    always_comb begin
        q_pop        = 1'b0;
        cnt_next     = cnt_reg;
        stop_next    = stop_reg;
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_found_next = m_found_reg;
        m_pos_next   = m_pos_reg;
        m_done_next  = m_done_reg;
        m_count_next = m_count_reg;
        if (!q_empty) begin
            if (!phase_reg && late_rep) begin
                if (can_load) begin
                    m_valid_next = 1'b1;
                    m_found_next = 1'b1;
                    m_pos_next   = q_head.late_pos;
                    m_done_next  = 1'b0;
                    m_count_next = cnt_late;
                    cnt_next     = cnt_late;
                    stop_next    = stop_reg ||
                                   (match_limit != 16'd0 && cnt_late >= match_limit);
                    if (q_head.last) begin
                        phase_next = 1'b1;
                    end else begin
                        q_pop = 1'b1;
                    end
                end
            end else if (q_head.last) begin
                // End item; stream counters return to reset after it
                if (can_load) begin
                    m_valid_next = 1'b1;
                    m_found_next = end_rep;
                    m_pos_next   = end_rep ? q_head.end_pos : 32'd0;
                    m_done_next  = 1'b1;
                    m_count_next = cnt_end;
                    cnt_next     = 16'd0;
                    stop_next    = 1'b0;
                    phase_next   = 1'b0;
                    q_pop        = 1'b1;
                end
            end else begin
                // Candidate blocked by the limit: drop it
                q_pop = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cnt_reg     <= 16'd0;
            stop_reg    <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            stop_reg    <= stop_next;
            phase_reg   <= phase_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
        m_pos_reg   <= m_pos_next;
        m_done_reg  <= m_done_next;
        m_count_reg <= m_count_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_match_found    = m_found_reg;
    assign m_match_position = m_pos_reg;
    assign m_search_done    = m_done_reg;
    assign m_matches_so_far = m_count_reg;

endmodule
`default_nettype wire

@@ rtl/core/substring_search_whole_word_unit.sv @@
// A byte's result is held in a queue slot and then in the output register
// (a match itself is decided on the byte that follows it). Throughput: 1
// byte per cycle while the queue is not full, set by the combinational
// window compare in the front; a last byte that yields both a late match
// and an end item gives two results in the back. Synchronous active-low reset
// clears stream state, queue and output valid flag, loads register defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// substring_search_whole_word_unit: streaming pattern search
// Front classifies each text byte against the pattern window, a short queue
// decouples it from the back, which applies the match limit and reports.
// ----------------------------------------------------------------------------
module substring_search_whole_word_unit #(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata,
    // Text byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_text_byte,
    input  wire logic        s_last_byte,
    // Result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_match_found,
    output logic [31:0]      m_match_position,
    output logic             m_search_done,
    output logic [15:0]      m_matches_so_far
);

    ssww_pkg::cfg_t     cfg_reg;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    ssww_pkg::q_entry_t q_entry;
    ssww_pkg::q_entry_t q_head;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_low    <= 64'd0;
            cfg_reg.pattern_high   <= 64'd0;
            cfg_reg.pattern_length <= 5'd1;
            cfg_reg.ignore_case    <= 1'b0;
            cfg_reg.whole_word     <= 1'b0;
            cfg_reg.match_limit    <= 16'd1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ssww_pkg::REG_PATTERN_LOW:  cfg_reg.pattern_low    <= cfg_wdata;
                ssww_pkg::REG_PATTERN_HIGH: cfg_reg.pattern_high   <= cfg_wdata;
                ssww_pkg::REG_PATTERN_LEN:  cfg_reg.pattern_length <= cfg_wdata[4:0];
                ssww_pkg::REG_IGNORE_CASE:  cfg_reg.ignore_case    <= cfg_wdata[0];
                ssww_pkg::REG_WHOLE_WORD:   cfg_reg.whole_word     <= cfg_wdata[0];
                ssww_pkg::REG_MATCH_LIMIT:  cfg_reg.match_limit    <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    ssww_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .s_last_byte (s_last_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    ssww_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_entry (q_entry),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_head  (q_head)
    );

    ssww_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .match_limit      (cfg_reg.match_limit),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_match_found    (m_match_found),
        .m_match_position (m_match_position),
        .m_search_done    (m_search_done),
        .m_matches_so_far (m_matches_so_far)
    );

`ifndef ASSERT_OFF
    // A result without a match carries no position
    a_nomatch_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_match_found |-> m_match_position == 32'd0)
        else $error("position set on a result without a match");

    // A reported match is always counted
    a_match_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_match_found |-> m_matches_so_far != 16'd0)
        else $error("match reported with zero count");

    // The count restarts after the end item of a text
    a_count_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_search_done |=>
            !m_valid || !m_match_found || m_matches_so_far == 16'd1)
        else $error("match count not restarted after end of text");
`endif

endmodule
`default_nettype wire
